[sv/pef_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pef_pkg
// Widths, reset value and sideband types shared by the pair force pipeline.
// ----------------------------------------------------------------------------
package pef_pkg;

  localparam int PW  = 32;   // position field
  localparam int CHW = 8;    // charge field
  localparam int DW  = 33;   // |d| per axis, unsigned Q17.16
  localparam int SW  = 66;   // s = |d|^2
  localparam int RW  = 33;   // floor(sqrt(s))
  localparam int CW  = 99;   // cube s * L
  localparam int KW  = 32;   // coupling constant
  localparam int QMW = 15;   // |q1*q2|
  localparam int KQW = 47;   // k * |q1*q2|
  localparam int NW  = 103;  // numerator k*|qq|*|d|*2^24
  localparam int QW  = 48;   // quotient bits kept
  localparam int FW  = 48;   // force field

  localparam logic [KW-1:0] RESET_K = 32'd596723297;
  localparam logic [FW-1:0] F_MAX   = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0] F_MIN   = {1'b1, {(FW-1){1'b0}}};

  typedef struct packed {
    logic [2:0] neg;   // result sign per axis
    logic       zero;  // coincident positions
  } flags_t;

  typedef struct packed {
    logic [2:0][NW-1:0] num;
    flags_t             flags;
  } side_t;

endpackage
`default_nettype wire

[sv/pef_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pef_front
// Four stages: displacement and charge product, partial squares and k*|qq|,
// squared length and numerator partials, numerator sum.
// ----------------------------------------------------------------------------
module pef_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_vld,
  input  wire logic [2:0][pef_pkg::PW-1:0] pos_a,
  input  wire logic [2:0][pef_pkg::PW-1:0] pos_b,
  input  wire logic [pef_pkg::CHW-1:0]     q_a,
  input  wire logic [pef_pkg::CHW-1:0]     q_b,
  input  wire logic [pef_pkg::KW-1:0]      k,
  output logic                             out_vld,
  output logic [pef_pkg::SW-1:0]           s_o,
  output pef_pkg::side_t                   side_o
);

  // stage 1
  logic [2:0]                    vld_r;
  logic                          vld4_r;
  logic [2:0][pef_pkg::DW-1:0]   mag1_r;
  logic [2:0]                    neg1_r;
  logic [pef_pkg::QMW-1:0]       qmag1_r;

  logic [2:0][pef_pkg::DW-1:0]   mag1_nxt;
  logic [2:0]                    neg1_nxt;
  logic [15:0]                   qq;
  logic [15:0]                   qmag_full;

  always_comb begin
    logic [pef_pkg::DW-1:0] dd;
    qq        = 16'({{8{q_a[7]}}, q_a} * {{8{q_b[7]}}, q_b});
    qmag_full = qq[15] ? 16'(-qq) : qq;
    for (int i = 0; i < 3; i++) begin
      dd          = {pos_a[i][31], pos_a[i]} - {pos_b[i][31], pos_b[i]};
      mag1_nxt[i] = dd[32] ? pef_pkg::DW'(-dd) : dd;
      neg1_nxt[i] = dd[32] != qq[15];
    end
  end

  // stage 2
  logic [2:0][63:0]              sq2_r;
  logic [2:0][pef_pkg::DW-1:0]   mag2_r;
  logic [2:0]                    neg2_r;
  logic [pef_pkg::KQW-1:0]       kq2_r;

  // stage 3
  logic [pef_pkg::SW-1:0]        s3_r;
  logic [2:0][63:0]              pl3_r;
  logic [2:0][46:0]              ph3_r;
  logic [2:0]                    dh3_r;
  logic [2:0]                    neg3_r;
  logic [pef_pkg::KQW-1:0]       kq3_r;

  logic [pef_pkg::SW-1:0]        s3_nxt;

  always_comb begin
    s3_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      s3_nxt = s3_nxt + {2'b00, sq2_r[i]};
      if (mag2_r[i][32]) begin
        s3_nxt = s3_nxt + {1'b0, mag2_r[i][31:0], 33'd0} + (66'd1 << 64);
      end
    end
  end

  // stage 4
  logic [pef_pkg::SW-1:0]        s4_r;
  pef_pkg::side_t                side4_r;
  pef_pkg::side_t                side4_nxt;

  always_comb begin
    logic [78:0] nb;
    for (int i = 0; i < 3; i++) begin
      nb = {15'd0, pl3_r[i]} + {ph3_r[i], 32'd0};
      if (dh3_r[i]) nb = nb + {kq3_r, 32'd0};
      side4_nxt.num[i] = {nb, 24'd0};
    end
    side4_nxt.flags.neg  = neg3_r;
    side4_nxt.flags.zero = (s3_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[1:0], in_vld};
      vld4_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= mag1_nxt;
      neg1_r  <= neg1_nxt;
      qmag1_r <= qmag_full[14:0];
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= mag1_r[i][31:0] * mag1_r[i][31:0];
        pl3_r[i] <= kq2_r[31:0] * mag2_r[i][31:0];
        ph3_r[i] <= kq2_r[46:32] * mag2_r[i][31:0];
        dh3_r[i] <= mag2_r[i][32];
      end
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      kq2_r   <= pef_pkg::KQW'(k) * pef_pkg::KQW'(qmag1_r);
      s3_r    <= s3_nxt;
      neg3_r  <= neg2_r;
      kq3_r   <= kq2_r;
      s4_r    <= s3_r;
      side4_r <= side4_nxt;
    end
  end

  assign out_vld = vld4_r;
  assign s_o     = s4_r;
  assign side_o  = side4_r;

endmodule
`default_nettype wire

[sv/pef_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pef_sqrt
// Integer square root, one root bit per stage, sideband carried alongside.
// ----------------------------------------------------------------------------
module pef_sqrt (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_vld,
  input  wire logic [pef_pkg::SW-1:0] s_i,
  input  wire pef_pkg::side_t         side_i,
  output logic                        out_vld,
  output logic [pef_pkg::SW-1:0]      s_o,
  output logic [pef_pkg::RW-1:0]      root_o,
  output pef_pkg::side_t              side_o
);

  localparam int RN = pef_pkg::RW;

  logic                   vld_r  [RN];
  logic [pef_pkg::SW-1:0] rem_r  [RN];
  logic [pef_pkg::RW-1:0] root_r [RN];
  logic [pef_pkg::SW-1:0] s_r    [RN];
  pef_pkg::side_t         side_r [RN];

  for (genvar g = 0; g < RN; g++) begin : g_st
    localparam int B = RN - 1 - g;
    logic                   vld_i;
    logic [pef_pkg::SW-1:0] rem_i;
    logic [pef_pkg::RW-1:0] root_i;
    logic [pef_pkg::SW-1:0] s_src;
    pef_pkg::side_t         side_src;
    logic [67:0]            trial;
    logic                   take;

    if (g == 0) begin : g_head
      assign vld_i    = in_vld;
      assign rem_i    = s_i;
      assign root_i   = '0;
      assign s_src    = s_i;
      assign side_src = side_i;
    end else begin : g_body
      assign vld_i    = vld_r[g-1];
      assign rem_i    = rem_r[g-1];
      assign root_i   = root_r[g-1];
      assign s_src    = s_r[g-1];
      assign side_src = side_r[g-1];
    end

    // trial = (root << (b+1)) + 4^b, remainder holds s - root^2
    assign trial = ({35'd0, root_i} << (B + 1)) + (68'd1 << (2 * B));
    assign take  = {2'b00, rem_i} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= take ? rem_i - trial[pef_pkg::SW-1:0] : rem_i;
        root_r[g] <= take ? root_i | (pef_pkg::RW'(1) << B) : root_i;
        s_r[g]    <= s_src;
        side_r[g] <= side_src;
      end
    end
  end

  assign out_vld = vld_r[RN-1];
  assign s_o     = s_r[RN-1];
  assign root_o  = root_r[RN-1];
  assign side_o  = side_r[RN-1];

endmodule
`default_nettype wire

[sv/pef_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pef_div
// Three-lane restoring divider over a shared denominator: one range stage,
// then one quotient bit per stage.
// ----------------------------------------------------------------------------
module pef_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_vld,
  input  wire logic [2:0][pef_pkg::NW-1:0] num_i,
  input  wire logic [pef_pkg::CW-1:0]      den_i,
  input  wire pef_pkg::flags_t             flags_i,
  output logic                             out_vld,
  output logic [2:0][pef_pkg::QW-1:0]      q_o,
  output logic [2:0]                       ovf_o,
  output pef_pkg::flags_t                  flags_o
);

  localparam int QN = pef_pkg::QW;
  localparam int TW = pef_pkg::CW + QN;   // widest shifted denominator

  // range stage
  logic                        vld0_r;
  logic [2:0][pef_pkg::NW-1:0] rem0_r;
  logic [2:0]                  ovf0_r;
  logic [pef_pkg::CW-1:0]      den0_r;
  pef_pkg::flags_t             flags0_r;

  logic [2:0]                  ovf0_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ovf0_nxt[l] = {(TW - pef_pkg::NW)'(0), num_i[l]} >= {den_i, (QN)'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r   <= num_i;
      ovf0_r   <= ovf0_nxt;
      den0_r   <= den_i;
      flags0_r <= flags_i;
    end
  end

  logic                        vld_r   [QN];
  logic [2:0][pef_pkg::NW-1:0] rem_r   [QN];
  logic [2:0][pef_pkg::QW-1:0] q_r     [QN];
  logic [2:0]                  ovf_r   [QN];
  logic [pef_pkg::CW-1:0]      den_r   [QN];
  pef_pkg::flags_t             flags_r [QN];

  for (genvar g = 0; g < QN; g++) begin : g_st
    localparam int I = QN - 1 - g;
    logic                        vld_i;
    logic [2:0][pef_pkg::NW-1:0] rem_i;
    logic [2:0][pef_pkg::QW-1:0] q_i;
    logic [2:0]                  ovf_i;
    logic [pef_pkg::CW-1:0]      den_src;
    pef_pkg::flags_t             flags_src;
    logic [TW-1:0]               trial;
    logic [2:0][pef_pkg::NW-1:0] rem_nxt;
    logic [2:0][pef_pkg::QW-1:0] q_nxt;

    if (g == 0) begin : g_head
      assign vld_i     = vld0_r;
      assign rem_i     = rem0_r;
      assign q_i       = '0;
      assign ovf_i     = ovf0_r;
      assign den_src   = den0_r;
      assign flags_src = flags0_r;
    end else begin : g_body
      assign vld_i     = vld_r[g-1];
      assign rem_i     = rem_r[g-1];
      assign q_i       = q_r[g-1];
      assign ovf_i     = ovf_r[g-1];
      assign den_src   = den_r[g-1];
      assign flags_src = flags_r[g-1];
    end

    assign trial = {(QN)'(0), den_src} << I;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if ({(TW - pef_pkg::NW)'(0), rem_i[l]} >= trial) begin
          rem_nxt[l] = rem_i[l] - trial[pef_pkg::NW-1:0];
          q_nxt[l]   = q_i[l] | (pef_pkg::QW'(1) << I);
        end else begin
          rem_nxt[l] = rem_i[l];
          q_nxt[l]   = q_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]   <= rem_nxt;
        q_r[g]     <= q_nxt;
        ovf_r[g]   <= ovf_i;
        den_r[g]   <= den_src;
        flags_r[g] <= flags_src;
      end
    end
  end

  assign out_vld = vld_r[QN-1];
  assign q_o     = q_r[QN-1];
  assign ovf_o   = ovf_r[QN-1];
  assign flags_o = flags_r[QN-1];

endmodule
`default_nettype wire

[sv/pair_electrostatic_force_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pair_electrostatic_force_top
// Coulomb force on the first of two point charges, k*q1*q2*d/|d|^3, Q24.24.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  positions Q16.16, charges
//  out_     output     out_valid / out_stall forces Q24.24, two flags
//  cfg_     input      cfg_wr_en            coupling constant Q0.32
//
//  One beat in per cycle while in_stall is low; the stages run front end,
//  33 square-root bits, cube, divider (range check, 48 quotient bits), output.
//  The whole pipeline holds while a result waits and out_stall is high.
//  Synchronous active-low reset clears the valid bits and loads k.
// ----------------------------------------------------------------------------
module pair_electrostatic_force_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [pef_pkg::PW-1:0]    in_first_x,
  input  wire logic signed [pef_pkg::PW-1:0]    in_first_y,
  input  wire logic signed [pef_pkg::PW-1:0]    in_first_z,
  input  wire logic signed [pef_pkg::CHW-1:0]   in_first_charge,
  input  wire logic signed [pef_pkg::PW-1:0]    in_second_x,
  input  wire logic signed [pef_pkg::PW-1:0]    in_second_y,
  input  wire logic signed [pef_pkg::PW-1:0]    in_second_z,
  input  wire logic signed [pef_pkg::CHW-1:0]   in_second_charge,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [pef_pkg::FW-1:0]         out_force_x,
  output logic signed [pef_pkg::FW-1:0]         out_force_y,
  output logic signed [pef_pkg::FW-1:0]         out_force_z,
  output logic                                  out_zero_distance,
  output logic                                  out_saturated,
  input  wire logic                             cfg_wr_en,
  input  wire logic [pef_pkg::KW-1:0]           cfg_wr_data
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [pef_pkg::KW-1:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= pef_pkg::RESET_K;
    end else if (cfg_wr_en) begin
      k_r <= cfg_wr_data;
    end
  end

  // front end
  logic                   fr_vld;
  logic [pef_pkg::SW-1:0] fr_s;
  pef_pkg::side_t         fr_side;

  pef_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .pos_a  ({in_first_z, in_first_y, in_first_x}),
    .pos_b  ({in_second_z, in_second_y, in_second_x}),
    .q_a    (in_first_charge),
    .q_b    (in_second_charge),
    .k      (k_r),
    .out_vld(fr_vld),
    .s_o    (fr_s),
    .side_o (fr_side)
  );

  // square root
  logic                   sq_vld;
  logic [pef_pkg::SW-1:0] sq_s;
  logic [pef_pkg::RW-1:0] sq_root;
  pef_pkg::side_t         sq_side;

  pef_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (fr_vld),
    .s_i    (fr_s),
    .side_i (fr_side),
    .out_vld(sq_vld),
    .s_o    (sq_s),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // cube s * L from 32x32 partial products
  logic                   c1_vld_r, c2_vld_r;
  logic [63:0]            p00_r, p10_r;
  logic [33:0]            p20_r;
  logic                   r1_r;
  logic [pef_pkg::SW-1:0] c1_s_r;
  pef_pkg::side_t         c1_side_r, c2_side_r;
  logic [pef_pkg::CW-1:0] cube_r, cube_nxt;

  always_comb begin
    cube_nxt = {35'd0, p00_r} + {3'd0, p10_r, 32'd0} + {1'b0, p20_r, 64'd0};
    if (r1_r) cube_nxt = cube_nxt + {1'b0, c1_s_r, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
    end else if (en) begin
      c1_vld_r <= sq_vld;
      c2_vld_r <= c1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r     <= sq_s[31:0] * sq_root[31:0];
      p10_r     <= sq_s[63:32] * sq_root[31:0];
      p20_r     <= sq_s[65:64] * sq_root[31:0];
      r1_r      <= sq_root[32];
      c1_s_r    <= sq_s;
      c1_side_r <= sq_side;
      cube_r    <= cube_nxt;
      c2_side_r <= c1_side_r;
    end
  end

  // divider
  logic                          dv_vld;
  logic [2:0][pef_pkg::QW-1:0]   dv_q;
  logic [2:0]                    dv_ovf;
  pef_pkg::flags_t               dv_flags;

  pef_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (c2_vld_r),
    .num_i  (c2_side_r.num),
    .den_i  (cube_r),
    .flags_i(c2_side_r.flags),
    .out_vld(dv_vld),
    .q_o    (dv_q),
    .ovf_o  (dv_ovf),
    .flags_o(dv_flags)
  );

  // clip, sign and output register
  logic                        out_vld_r;
  logic [2:0][pef_pkg::FW-1:0] force_r, force_nxt;
  logic                        zd_r, sat_r, sat_nxt;

  always_comb begin
    logic [pef_pkg::FW-1:0] lim;
    logic [pef_pkg::FW-1:0] m;
    sat_nxt = 1'b0;
    for (int l = 0; l < 3; l++) begin
      lim = dv_flags.neg[l] ? pef_pkg::F_MIN : pef_pkg::F_MAX;
      m   = dv_q[l];
      if (dv_ovf[l] || dv_q[l] > lim) begin
        m       = lim;
        sat_nxt = 1'b1;
      end
      force_nxt[l] = dv_flags.neg[l] ? pef_pkg::FW'(-m) : m;
    end
    // coincident positions: zero force, no clipping
    if (dv_flags.zero) begin
      force_nxt = '0;
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_r <= force_nxt;
      zd_r    <= dv_flags.zero;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_force_x       = force_r[0];
  assign out_force_y       = force_r[1];
  assign out_force_z       = force_r[2];
  assign out_zero_distance = zd_r;
  assign out_saturated     = sat_r;

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_distance |->
      out_force_x == '0 && out_force_y == '0 && out_force_z == '0 && !out_saturated)
    else $error("zero distance with non-zero force");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_force_x == pef_pkg::F_MAX || out_force_x == pef_pkg::F_MIN ||
      out_force_y == pef_pkg::F_MAX || out_force_y == pef_pkg::F_MIN ||
      out_force_z == pef_pkg::F_MAX || out_force_z == pef_pkg::F_MIN)
    else $error("saturated flag without a clipped component");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input held while output free");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(force_r) && $stable(sat_r))
    else $error("held result changed");

endmodule
`default_nettype wire
